FILE: rtl/salc_pkg.sv
package salc_pkg;

  // default sizes
  localparam int DEF_MAX_SETS   = 64;
  localparam int DEF_MAX_WAYS   = 8;
  localparam int DEF_ADDR_WIDTH = 64;

  // fixed field widths
  localparam int TAG_W   = 62;
  localparam int TOTAL_W = 32;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 6;
  localparam int CIDX_W  = 2;
  localparam int SRAW_W  = 7;
  localparam int SIB_W   = 3;
  localparam int WAYS_W  = 4;
  localparam int OFF_W   = 6;

  // access kinds
  localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_WAYS     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_OFF_BITS = 2'd2;

  // configuration reset values
  localparam logic [SIB_W-1:0]  RST_SET_BITS = 3'd1;
  localparam logic [WAYS_W-1:0] RST_WAYS     = 4'd1;
  localparam logic [OFF_W-1:0]  RST_OFF_BITS = 6'd4;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clear;
    logic rd;
    logic lookup;
    logic update;
    logic last;
  } salc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic modify;
  } salc_stat_t;

endpackage

FILE: rtl/salc_ctrl.sv
module salc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  salc_pkg::salc_stat_t stat_i,
  output salc_pkg::salc_cmd_t  cmd_o
);
  import salc_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_LOOKUP = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       second_q, second_d;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    cmd_o    = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          second_d   = 1'b0;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        if (stat_i.modify && !second_q) begin
          cmd_o.last = 1'b0;
          second_d   = 1'b1;
          state_d    = S_READ;
        end else begin
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

FILE: rtl/salc_dp.sv
module salc_dp #(
  parameter int MAX_SETS   = salc_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS   = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  salc_pkg::salc_cmd_t           cmd_i,
  output salc_pkg::salc_stat_t          stat_o,
  input  logic                          cfg_we_i,
  input  logic [salc_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [salc_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [salc_pkg::MODE_W-1:0]   mode_i,
  input  logic [ADDR_WIDTH-1:0]         address_i,
  output logic                          valid_o,
  output logic                          was_hit_o,
  output logic                          was_miss_o,
  output logic                          was_eviction_o,
  output logic                          last_o,
  output logic [salc_pkg::TOTAL_W-1:0]  total_hits_o,
  output logic [salc_pkg::TOTAL_W-1:0]  total_misses_o,
  output logic [salc_pkg::TOTAL_W-1:0]  total_evictions_o
);
  import salc_pkg::*;

  localparam int SET_W  = $clog2(MAX_SETS);
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W  = WAY_W;
  localparam int ENT_W  = 1 + TAG_W + AGE_W;
  localparam int ROW_W  = MAX_WAYS * ENT_W;
  localparam int NRAW   = 1 << SRAW_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
  localparam logic [TOTAL_W-1:0] TOT_MAX = '1;

  // configuration registers
  logic [SIB_W-1:0]  sib_q;
  logic [WAYS_W-1:0] ways_q;
  logic [OFF_W-1:0]  off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sib_q  <= RST_SET_BITS;
      ways_q <= RST_WAYS;
      off_q  <= RST_OFF_BITS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS: sib_q  <= cfg_data_i[SIB_W-1:0];
        CFG_WAYS:     ways_q <= cfg_data_i[WAYS_W-1:0];
        CFG_OFF_BITS: off_q  <= cfg_data_i[OFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ways taking part: zero acts as one, large counts cover all ways
  logic [MAX_WAYS-1:0] use_w;
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      use_w[j] = (j == 0) || (int'(ways_q) > j);
    end
  end

  // set index reduction table
  logic [SET_W-1:0] mod_tbl [NRAW];
  for (genvar i = 0; i < NRAW; i++) begin : g_mod
    assign mod_tbl[i] = SET_W'(i % MAX_SETS);
  end

  // address split
  logic [63:0]       addr_ext;
  logic [63:0]       set_sh;
  logic [63:0]       tag_sh;
  logic [SRAW_W-1:0] set_mask;
  logic [SRAW_W-1:0] set_raw;
  logic [SRAW_W-1:0] hi_bits;

  always_comb begin
    addr_ext = 64'(address_i);
    set_sh   = addr_ext >> off_q;
    set_mask = SRAW_W'((8'd1 << sib_q) - 8'd1);
    set_raw  = set_sh[SRAW_W-1:0] & set_mask;
    hi_bits  = SRAW_W'(off_q) + SRAW_W'(sib_q);
    tag_sh   = addr_ext >> hi_bits;
  end

  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             modify_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      set_q    <= mod_tbl[set_raw];
      tag_q    <= tag_sh[TAG_W-1:0];
      modify_q <= (mode_i == MODE_MODIFY);
    end
  end

  // clearing pass counter
  logic [SET_W-1:0] clr_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + SET_W'(1);
    end
  end

  assign stat_o.clear_done = (clr_cnt_q == SET_W'(MAX_SETS - 1));
  assign stat_o.modify     = modify_q;

  // set memory, one row per set
  logic [ROW_W-1:0] mem_q [MAX_SETS];
  logic [ROW_W-1:0] rd_row_q;
  logic [ROW_W-1:0] new_row;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (cmd_i.update) begin
      mem_q[set_q] <= new_row;
    end
    if (cmd_i.rd) begin
      rd_row_q <= mem_q[set_q];
    end
  end

  // unpack the row
  logic [MAX_WAYS-1:0] row_valid;
  logic [TAG_W-1:0]    row_tag [MAX_WAYS];
  logic [AGE_W-1:0]    row_age [MAX_WAYS];

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      row_valid[j] = rd_row_q[j*ENT_W + TAG_W + AGE_W];
      row_tag[j]   = rd_row_q[j*ENT_W + AGE_W +: TAG_W];
      row_age[j]   = rd_row_q[j*ENT_W +: AGE_W];
    end
  end

  // lookup: hit way, first free way, lru victim
  logic             hit_any, inv_any;
  logic [WAY_W-1:0] hit_way, inv_way, vic_way, sel_way;
  logic [AGE_W-1:0] best_age;

  always_comb begin
    hit_any  = 1'b0;
    inv_any  = 1'b0;
    hit_way  = '0;
    inv_way  = '0;
    vic_way  = '0;
    best_age = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (use_w[j] && row_valid[j] && (row_tag[j] == tag_q)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(j);
      end
      if (use_w[j] && !row_valid[j]) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(j);
      end
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (use_w[j] && (row_age[j] >= best_age)) begin
        best_age = row_age[j];
        vic_way  = WAY_W'(j);
      end
    end
    if (hit_any) begin
      sel_way = hit_way;
    end else if (inv_any) begin
      sel_way = inv_way;
    end else begin
      sel_way = vic_way;
    end
  end

  logic             hit_q, evict_q;
  logic [WAY_W-1:0] way_q;
  logic [AGE_W-1:0] old_age_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q     <= hit_any;
      evict_q   <= !hit_any && !inv_any;
      way_q     <= sel_way;
      old_age_q <= row_age[sel_way];
    end
  end

  // write-back row with lru ranks updated
  logic ref_valid;
  always_comb begin
    ref_valid = hit_q || evict_q;
    new_row   = rd_row_q;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (use_w[j]) begin
        if (WAY_W'(j) == way_q) begin
          new_row[j*ENT_W + TAG_W + AGE_W] = 1'b1;
          new_row[j*ENT_W +: AGE_W]        = '0;
          if (!hit_q) begin
            new_row[j*ENT_W + AGE_W +: TAG_W] = tag_q;
          end
        end else if (row_valid[j] && (!ref_valid || (row_age[j] < old_age_q)) &&
                     (row_age[j] < AGE_MAX)) begin
          new_row[j*ENT_W +: AGE_W] = row_age[j] + AGE_W'(1);
        end
      end
    end
  end

  // running totals, saturating
  logic [TOTAL_W-1:0] hits_q, misses_q, evicts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (cmd_i.update) begin
      if (hit_q) begin
        if (hits_q != TOT_MAX) begin
          hits_q <= hits_q + TOTAL_W'(1);
        end
      end else if (misses_q != TOT_MAX) begin
        misses_q <= misses_q + TOTAL_W'(1);
      end
      if (evict_q && (evicts_q != TOT_MAX)) begin
        evicts_q <= evicts_q + TOTAL_W'(1);
      end
    end
  end

  // result strobe
  logic valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.update;
    end
  end

  // result flags
  logic hit_out_q, evict_out_q, last_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_out_q   <= hit_q;
      evict_out_q <= evict_q;
      last_q      <= cmd_i.last;
    end
  end

  assign valid_o           = valid_q;
  assign was_hit_o         = hit_out_q;
  assign was_miss_o        = !hit_out_q;
  assign was_eviction_o    = evict_out_q;
  assign last_o            = last_q;
  assign total_hits_o      = hits_q;
  assign total_misses_o    = misses_q;
  assign total_evictions_o = evicts_q;

endmodule

FILE: rtl/set_assoc_lru_cache_sim.sv
// set-associative tag store with true lru replacement, hit/miss/eviction totals
//
// input: an access transaction (mode_i, address_i) is taken at a rising edge with
// start high and busy low. mode 2 (modify) gives two results, other modes one.
// output: each result shows for one cycle with valid_o high; the receiver cannot
// stall, so results are never held. last_o marks the final result of an access.
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 set index
// bits, 1 ways in use, 2 offset bits); write only while busy is low.
// timing: a load or store result follows a read, a lookup and a write-back step;
// the next access can be taken in the cycle valid_o is high, so an access is only
// taken once the previous one is done. a modify runs two such passes. each pass is
// a set read from the single-port row memory (registered data), then the lookup and
// the write-back.
// reset: totals clear, registers return to 1 / 1 / 4, and a clearing pass writes
// every set row, one per cycle, with busy high.
module set_assoc_lru_cache_sim #(
  parameter int MAX_SETS   = salc_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS   = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [salc_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [salc_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [salc_pkg::MODE_W-1:0]   mode_i,
  input  logic [ADDR_WIDTH-1:0]         address_i,
  output logic                          valid_o,
  output logic                          was_hit_o,
  output logic                          was_miss_o,
  output logic                          was_eviction_o,
  output logic                          last_o,
  output logic [salc_pkg::TOTAL_W-1:0]  total_hits_o,
  output logic [salc_pkg::TOTAL_W-1:0]  total_misses_o,
  output logic [salc_pkg::TOTAL_W-1:0]  total_evictions_o
);
  import salc_pkg::*;

  salc_cmd_t  cmd;
  salc_stat_t stat;

  // controller
  salc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // datapath
  salc_dp #(
    .MAX_SETS   (MAX_SETS),
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .mode_i            (mode_i),
    .address_i         (address_i),
    .valid_o           (valid_o),
    .was_hit_o         (was_hit_o),
    .was_miss_o        (was_miss_o),
    .was_eviction_o    (was_eviction_o),
    .last_o            (last_o),
    .total_hits_o      (total_hits_o),
    .total_misses_o    (total_misses_o),
    .total_evictions_o (total_evictions_o)
  );

  // an eviction is always a miss
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && was_eviction_o) |-> was_miss_o)
    else $error("eviction reported without a miss");

  // the second result of a modify follows after another read, lookup and write-back pass and hits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> ##3 (valid_o && last_o && was_hit_o))
    else $error("modify second pass did not hit");

  // an accepted access keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted access");

  // a result that is not the last leaves the block busy with its second pass pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy)
    else $error("block idle with a modify pass pending");

endmodule

FILE: test/tb_set_assoc_lru_cache_sim.sv
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_sim;

  import salc_pkg::*;

  localparam int NSETS          = DEF_MAX_SETS;
  localparam int NWAYS          = DEF_MAX_WAYS;
  localparam int LINES          = NSETS * NWAYS;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  // access kinds not named in the package, plus the unmapped register index
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_SPARE   = 2'd3;

  typedef enum logic [1:0] {
    ACC_HIT,
    ACC_FILL,
    ACC_EVICT
  } access_kind_e;

  typedef struct packed {
    logic               hit;
    logic               miss;
    logic               evict;
    logic               last;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evicts;
  } outcome_t;

  // tag store mirror with lru ranks and expected outcomes
  class cache_scoreboard;
    logic               line_ok   [LINES];
    logic [TAG_W-1:0]   line_tag  [LINES];
    logic [2:0]         line_rank [LINES];
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evicts;
    logic [SIB_W-1:0]   set_bits;
    logic [WAYS_W-1:0]  way_count;
    logic [OFF_W-1:0]   off_bits;
    outcome_t           expected_outcomes [$];
    int                 mismatches;

    function new();
      foreach (line_ok[i]) begin
        line_ok[i]   = 1'b0;
        line_tag[i]  = '0;
        line_rank[i] = '0;
      end
      hits       = '0;
      misses     = '0;
      evicts     = '0;
      set_bits   = RST_SET_BITS;
      way_count  = RST_WAYS;
      off_bits   = RST_OFF_BITS;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_SET_BITS: set_bits = data[SIB_W-1:0];
        CFG_WAYS:     way_count = data[WAYS_W-1:0];
        CFG_OFF_BITS: off_bits = data[OFF_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned ways_active();
      int unsigned n;
      n = way_count;
      if (n == 0) n = 1;
      if (n > NWAYS) n = NWAYS;
      return n;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    function logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // make way w most recently used, aging the younger valid lines
    function void promote(int unsigned base, int unsigned n, int unsigned w, bit was_valid);
      int unsigned old;
      int unsigned j;
      old = was_valid ? int'(line_rank[base + w]) : NWAYS;
      for (j = 0; j < n; j++) begin
        if (j != w && line_ok[base + j] && line_rank[base + j] < old &&
            line_rank[base + j] < NWAYS - 1)
          line_rank[base + j] = line_rank[base + j] + 1'b1;
      end
      line_rank[base + w] = '0;
    endfunction

    function access_kind_e lookup_once(int unsigned base, int unsigned n, logic [TAG_W-1:0] tag);
      int unsigned j;
      int unsigned victim;
      int unsigned best;
      for (j = 0; j < n; j++) begin
        if (line_ok[base + j] && line_tag[base + j] == tag) begin
          promote(base, n, j, 1'b1);
          hits = bump(hits);
          return ACC_HIT;
        end
      end
      misses = bump(misses);
      for (j = 0; j < n; j++) begin
        if (!line_ok[base + j]) begin
          promote(base, n, j, 1'b0);
          line_ok[base + j]  = 1'b1;
          line_tag[base + j] = tag;
          return ACC_FILL;
        end
      end
      // ties go to the highest-numbered way
      victim = 0;
      best   = 0;
      for (j = 0; j < n; j++) begin
        if (line_rank[base + j] >= best) begin
          best   = line_rank[base + j];
          victim = j;
        end
      end
      promote(base, n, victim, 1'b1);
      line_tag[base + victim] = tag;
      evicts = bump(evicts);
      return ACC_EVICT;
    endfunction

    function void push_outcome(access_kind_e kind, logic last);
      outcome_t o;
      o.hit    = (kind == ACC_HIT);
      o.miss   = (kind != ACC_HIT);
      o.evict  = (kind == ACC_EVICT);
      o.last   = last;
      o.hits   = hits;
      o.misses = misses;
      o.evicts = evicts;
      expected_outcomes.push_back(o);
    endfunction

    // accepted access transaction: split the address and run the lookup(s)
    function void record_access(logic [MODE_W-1:0] mode, logic [63:0] addr);
      logic [63:0]  set_sel;
      logic [63:0]  tag_sel;
      int unsigned  hi;
      int unsigned  base;
      int unsigned  n;
      access_kind_e kind;
      set_sel = addr >> off_bits;
      set_sel = set_sel & ((64'd1 << set_bits) - 64'd1);
      set_sel = set_sel % NSETS;
      hi      = off_bits + set_bits;
      tag_sel = (hi < 64) ? (addr >> hi) : 64'd0;
      base    = int'(set_sel[5:0]) * NWAYS;
      n       = ways_active();
      kind    = lookup_once(base, n, tag_sel[TAG_W-1:0]);
      if (mode == MODE_MODIFY) begin
        push_outcome(kind, 1'b0);
        kind = lookup_once(base, n, tag_sel[TAG_W-1:0]);
        push_outcome(kind, 1'b1);
      end else begin
        push_outcome(kind, 1'b1);
      end
    endfunction

    function void compare_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $error("result with no pending access");
        mismatches++;
        return;
      end
      want = expected_outcomes.pop_front();
      compare_field("was_hit", TOTAL_W'(want.hit), TOTAL_W'(got.hit));
      compare_field("was_miss", TOTAL_W'(want.miss), TOTAL_W'(got.miss));
      compare_field("was_eviction", TOTAL_W'(want.evict), TOTAL_W'(got.evict));
      compare_field("last", TOTAL_W'(want.last), TOTAL_W'(got.last));
      compare_field("total_hits", want.hits, got.hits);
      compare_field("total_misses", want.misses, got.misses);
      compare_field("total_evictions", want.evicts, got.evicts);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                cfg_we_i;
  logic [CIDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic [MODE_W-1:0]   mode_i;
  logic [63:0]         address_i;
  logic                valid_o;
  logic                was_hit_o;
  logic                was_miss_o;
  logic                was_eviction_o;
  logic                last_o;
  logic [TOTAL_W-1:0]  total_hits_o;
  logic [TOTAL_W-1:0]  total_misses_o;
  logic [TOTAL_W-1:0]  total_evictions_o;

  cache_scoreboard scoreboard = new();
  int              stall_cycles = 0;
  int              failures;

  set_assoc_lru_cache_sim i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .mode_i            (mode_i),
    .address_i         (address_i),
    .valid_o           (valid_o),
    .was_hit_o         (was_hit_o),
    .was_miss_o        (was_miss_o),
    .was_eviction_o    (was_eviction_o),
    .last_o            (last_o),
    .total_hits_o      (total_hits_o),
    .total_misses_o    (total_misses_o),
    .total_evictions_o (total_evictions_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // monitor: results, accepted transactions and register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o)
        scoreboard.check_outcome({was_hit_o, was_miss_o, was_eviction_o, last_o,
                                  total_hits_o, total_misses_o, total_evictions_o});
      if (start && !busy) scoreboard.record_access(mode_i, address_i);
      if (cfg_we_i) scoreboard.write_reg(cfg_idx_i, cfg_data_i);
    end
    if (rst_ni && ((start && !busy) || valid_o)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  // watchdog
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("set_assoc_lru_cache_sim: mismatch");
    $finish;
  end

  // hold start high until the block takes the transaction
  task automatic send_access(input logic [MODE_W-1:0] mode, input logic [63:0] addr);
    @(negedge clk_i);
    start     <= 1'b1;
    mode_i    <= mode;
    address_i <= addr;
    do @(posedge clk_i); while (busy);
  endtask

  // gap with noise on the payload
  task automatic idle_cycles(input int n);
    @(negedge clk_i);
    start     <= 1'b0;
    mode_i    <= MODE_W'($urandom);
    address_i <= {$urandom, $urandom};
    repeat (n) @(posedge clk_i);
  endtask

  // wait for every expected result, the tail latency, and busy low
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic configure(input logic [CFG_W-1:0] set_cfg, input logic [CFG_W-1:0] ways_cfg,
                           input logic [CFG_W-1:0] off_cfg);
    write_reg(CFG_SET_BITS, set_cfg);
    write_reg(CFG_WAYS, ways_cfg);
    write_reg(CFG_OFF_BITS, off_cfg);
    write_reg(CFG_SPARE, CFG_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly addresses that collide on a few sets with a few tags
  function automatic logic [63:0] pick_address();
    logic [63:0] tag_part;
    logic [63:0] set_part;
    logic [63:0] low_part;
    int unsigned hi;
    if ($urandom_range(0, 6) == 0) return {$urandom, $urandom};
    hi       = scoreboard.off_bits + scoreboard.set_bits;
    tag_part = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, scoreboard.ways_active() + 2));
    set_part = 64'($urandom_range(0, 3)) & ((64'd1 << scoreboard.set_bits) - 64'd1);
    low_part = {$urandom, $urandom} & ((64'd1 << scoreboard.off_bits) - 64'd1);
    return (tag_part << hi) | (set_part << scoreboard.off_bits) | low_part;
  endfunction

  task automatic run_random(input int count);
    int sent;
    int burst;
    int i;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (i = 0; i < burst && sent < count; i++) begin
        send_access(MODE_W'($urandom_range(0, 3)), pick_address());
        sent++;
      end
      if ($urandom_range(0, 3) != 0)
        idle_cycles($urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4));
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] set_cfg, input logic [CFG_W-1:0] ways_cfg,
                           input logic [CFG_W-1:0] off_cfg, input int count);
    drain();
    configure(set_cfg, ways_cfg, off_cfg);
    run_random(count);
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    mode_i     = '0;
    address_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // directed, reset configuration: one way, two sets, 16-byte blocks
    send_access(MODE_LOAD, 64'h0);
    send_access(MODE_LOAD, 64'h0);
    send_access(MODE_STORE, '1);
    send_access(MODE_MODIFY, 64'h10);
    send_access(MODE_UNUSED, 64'h20);
    send_access(MODE_MODIFY, 64'h2F);
    send_access(MODE_LOAD, 64'h8000_0000_0000_0000);
    send_access(MODE_STORE, 64'h5555_5555_5555_5555);
    send_access(MODE_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
    send_access(MODE_LOAD, 64'h5555_5555_5555_5555);

    // directed, four ways: fill one set, then evict the oldest
    drain();
    configure(6'd2, 6'd4, 6'd4);
    send_access(MODE_LOAD, 64'h040);
    send_access(MODE_STORE, 64'h080);
    send_access(MODE_MODIFY, 64'h0C0);
    send_access(MODE_LOAD, 64'h100);
    send_access(MODE_LOAD, 64'h040);
    send_access(MODE_STORE, 64'h140);
    send_access(MODE_LOAD, 64'h080);

    // configuration sweep with random traffic
    run_phase(6'd2, 6'd4, 6'd4, 150);
    run_phase(6'd0, 6'd1, 6'd1, 150);   // no set bits, tag keeps low bits only
    run_phase(6'd6, 6'd8, 6'd32, 150);
    run_phase(6'd7, 6'd0, 6'd6, 150);   // set index wraps, zero ways acts as one
    run_phase(6'd3, 6'd15, 6'd5, 150);  // way count clamps to the maximum
    run_phase(6'd1, 6'd2, 6'd63, 120);  // tag lies past the address
    run_phase(6'd6, 6'd8, 6'd58, 120);
    run_phase(6'd4, 6'd3, 6'd0, 150);
    run_phase(6'd0, 6'd9, 6'd0, 120);   // the tag is the low 62 bits of the address
    // resize ways while lines stay valid, so ranks can tie
    run_phase(6'd1, 6'd8, 6'd3, 150);
    run_phase(6'd1, 6'd3, 6'd3, 150);
    run_phase(6'd1, 6'd6, 6'd3, 150);
    repeat (3) run_phase(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), 150);

    drain();
    failures = scoreboard.mismatches;
    if (scoreboard.pending() != 0) begin
      $error("%0d expected results never arrived", scoreboard.pending());
      failures++;
    end
    if (failures == 0) $display("set_assoc_lru_cache_sim: match");
    else $display("set_assoc_lru_cache_sim: mismatch");
    $finish;
  end

endmodule

FILE: set_assoc_lru_cache_sim.f
rtl/salc_pkg.sv
rtl/salc_ctrl.sv
rtl/salc_dp.sv
rtl/set_assoc_lru_cache_sim.sv
test/tb_set_assoc_lru_cache_sim.sv
